@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the front end, job queue and output sequencer of the character window extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must be true at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must be true whenever a trigger is seen in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

@@ hw/rtl/ucwe_pkg.sv @@
// Package with the types, constants and helper functions of the character window extractor.
`default_nettype none

package ucwe_pkg;

    localparam int INDEX_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH           = 16;
    localparam int TOTAL_WIDTH         = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int MAX_CHAR_BYTES      = 4;

    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = 16'hFFFF;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_START_CHAR = 2'd0;
    localparam logic [1:0] CFG_CHAR_COUNT = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] START_CHAR_RESET = 16'd0;
    localparam logic [CFG_WIDTH-1:0] CHAR_COUNT_RESET = 16'hFFFF;

    // Lead byte masks and patterns.
    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_PAT   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_PAT   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_PAT   = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PAT    = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   byte_present;
        logic                   last;
        logic [TOTAL_WIDTH-1:0] char_total;
        logic                   well_formed;
    } out_item_t;

    // One unit of work handed from the front end to the output sequencer.
    typedef struct packed {
        logic [MAX_CHAR_BYTES-1:0][7:0] bytes;
        logic [2:0]                     nbytes;
        logic                           eos;
        logic [TOTAL_WIDTH-1:0]         total;
        logic                           wf;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & ASCII_MASK) == 8'h00) begin
            len = 3'd1;
        end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ucwe_front.sv @@
// Front end: accepts bytes, assembles characters, applies the window and emits jobs.
`default_nettype none
`include "assert_macros.svh"

module ucwe_front #(
    parameter int INDEX_WIDTH = ucwe_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ucwe_pkg::in_item_t                  in_item,
    input  logic [ucwe_pkg::CFG_WIDTH-1:0]      start_char,
    input  logic [ucwe_pkg::CFG_WIDTH-1:0]      char_count,
    input  ucwe_pkg::q_status_t                 q_status,
    output logic                                push,
    output ucwe_pkg::job_t                      push_job
);
    import ucwe_pkg::*;

    localparam int CW = (INDEX_WIDTH > TOTAL_WIDTH) ? INDEX_WIDTH : TOTAL_WIDTH;
    localparam int WW = CW + 1;

    logic [MAX_CHAR_BYTES-1:0][7:0] buf_reg, buf_next;
    logic [2:0]                     fill_reg, fill_next;
    logic [2:0]                     len_reg, len_next;
    logic [INDEX_WIDTH-1:0]         idx_reg, idx_next;
    logic                           wf_reg, wf_next;

    logic                           accept;
    logic [7:0]                     b;
    logic                           eos;
    logic [2:0]                     cur_len;
    logic                           cont_bad;
    logic                           wf_cur;
    logic [2:0]                     fill_inc;
    logic [2:0]                     fill_after;
    logic                           complete;
    logic                           sel;
    logic [MAX_CHAR_BYTES-1:0][7:0] bytes_cur;
    logic [INDEX_WIDTH-1:0]         idx_inc;
    logic [INDEX_WIDTH-1:0]         idx_cur;
    logic [CW-1:0]                  idx_ext;
    logic [CW-1:0]                  idx_cur_ext;
    logic [TOTAL_WIDTH-1:0]         total;

    assign in_ready = ~q_status.full;
    assign accept   = in_valid & ~q_status.full;
    assign b        = in_item.data_byte;
    assign eos      = in_item.end_of_string;

    always_comb
    begin
        cur_len  = (fill_reg == 3'd0) ? lead_length(b) : len_reg;
        cont_bad = (fill_reg != 3'd0) && ((b & CONT_MASK) != CONT_PAT);
        wf_cur   = wf_reg & ~cont_bad;
        fill_inc = fill_reg + 3'd1;
        complete = (fill_inc >= cur_len);

        bytes_cur                = buf_reg;
        bytes_cur[fill_reg[1:0]] = b;

        // Window test on the index of the character now completing.
        idx_ext = CW'(idx_reg);
        sel     = (idx_ext >= CW'(start_char)) &&
                  ((WW'(idx_ext) - WW'(start_char)) < WW'(char_count));

        idx_inc     = (idx_reg != {INDEX_WIDTH{1'b1}}) ? idx_reg + INDEX_WIDTH'(1) : idx_reg;
        idx_cur     = complete ? idx_inc : idx_reg;
        idx_cur_ext = CW'(idx_cur);
        total       = (idx_cur_ext > CW'(TOTAL_MAX)) ? TOTAL_MAX
                                                     : idx_cur_ext[TOTAL_WIDTH-1:0];
        fill_after  = complete ? 3'd0 : fill_inc;

        push            = accept && (eos || (complete && sel));
        push_job.bytes  = bytes_cur;
        push_job.nbytes = (complete && sel) ? fill_inc : 3'd0;
        push_job.eos    = eos;
        push_job.total  = total;
        push_job.wf     = wf_cur & ~(eos & (fill_after != 3'd0));

        buf_next  = buf_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        wf_next   = wf_reg;
        if (accept)
        begin
            buf_next = bytes_cur;
            if (eos)
            begin
                fill_next = 3'd0;
                len_next  = 3'd0;
                idx_next  = '0;
                wf_next   = 1'b1;
            end
            else
            begin
                fill_next = fill_after;
                len_next  = cur_len;
                idx_next  = idx_cur;
                wf_next   = wf_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
            len_reg  <= 3'd0;
            idx_reg  <= '0;
            wf_reg   <= 1'b1;
        end
        else
        begin
            fill_reg <= fill_next;
            len_reg  <= len_next;
            idx_reg  <= idx_next;
            wf_reg   <= wf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    `ASSERT_HOLDS(a_fill_below_four, clk, rst_n, fill_reg < 3'd4, "character fill out of range")
    `ASSERT_IMPLIES(a_job_not_empty, clk, rst_n, push && !push_job.eos, push_job.nbytes != 3'd0, "job without bytes or end mark")

endmodule

`default_nettype wire

@@ hw/rtl/ucwe_queue.sv @@
// Job queue between the front end and the output sequencer.
`default_nettype none
`include "assert_macros.svh"

module ucwe_queue #(
    parameter int DEPTH = ucwe_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ucwe_pkg::job_t      push_job,
    input  logic                pop,
    output ucwe_pkg::job_t      head,
    output ucwe_pkg::q_status_t status
);
    import ucwe_pkg::*;

    // DEPTH is a power of two so that the pointers wrap on their own.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNTW'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, count_reg != '0, "pop from empty job queue")
    `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, count_reg != CNTW'(DEPTH), "push into full job queue")

endmodule

`default_nettype wire

@@ hw/rtl/ucwe_back.sv @@
// Output sequencer: job bytes, an end marker if eos; one per cycle while out_ready.
`default_nettype none
`include "assert_macros.svh"

module ucwe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ucwe_pkg::q_status_t q_status,
    input  ucwe_pkg::job_t      head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ucwe_pkg::out_item_t out_item
);
    import ucwe_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_item_reg, out_item_next;

    logic       load;
    logic       is_byte;
    logic       job_done;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        is_byte  = (pos_reg < head.nbytes);
        job_done = head.eos ? (pos_reg == head.nbytes) : ((pos_reg + 3'd1) == head.nbytes);
        load     = ~q_status.empty & (~out_valid_reg | out_ready);
        pop      = load & job_done;

        pos_next = pos_reg;
        if (load)
        begin
            pos_next = job_done ? 3'd0 : pos_reg + 3'd1;
        end

        out_item_next.out_byte     = is_byte ? head.bytes[pos_reg[1:0]] : 8'd0;
        out_item_next.byte_present = is_byte;
        out_item_next.last         = ~is_byte;
        out_item_next.char_total   = head.total;
        out_item_next.well_formed  = head.wf;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    `ASSERT_IMPLIES(a_marker_needs_eos, clk, rst_n, load && !is_byte, head.eos, "end marker from a job without end mark")

endmodule

`default_nettype wire

@@ hw/rtl/utf8_char_window_extract.sv @@
// Top level of the UTF-8 character window extractor: configuration registers and the pipeline.
//
// The block takes a UTF-8 string one byte per request on the input channel
// (in_valid/in_ready, payload in_item); end_of_string marks the last byte.
// Each complete character whose index lies in [start_char, start_char +
// char_count) comes out byte by byte on the output channel (out_valid/
// out_ready, payload out_item). On the end mark one end marker follows with
// the complete-character total and the well-formed flag; the next string then
// starts counting from zero. A character cut off by the end mark is dropped.
// The two registers are written through cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high, and writes belong in idle periods.
// A request passes the job queue and the output register before its first
// result; out_valid rises once that register is loaded. The input takes one
// byte per cycle while the queue has room; the output sequencer gives one
// result per cycle while the receiver takes them, so a selected four-byte
// character plus an end marker gives five results, which the four-entry queue absorbs.
// When the receiver stalls, the output register holds and the job queue fills;
// in_ready drops only once the queue is full. Reset empties the queue and the
// output register and restores the register defaults (start 0, count 65535).
`default_nettype none

module utf8_char_window_extract #(
    parameter int INDEX_WIDTH = ucwe_pkg::INDEX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ucwe_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ucwe_pkg::out_item_t            out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [ucwe_pkg::CFG_WIDTH-1:0] cfg_data
);
    import ucwe_pkg::*;

    logic [CFG_WIDTH-1:0] start_char_reg, start_char_next;
    logic [CFG_WIDTH-1:0] char_count_reg, char_count_next;

    q_status_t q_status;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    // Writes to an index past the register list are ignored.
    always_comb
    begin
        start_char_next = start_char_reg;
        char_count_next = char_count_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_CHAR: start_char_next = cfg_data;
                CFG_CHAR_COUNT: char_count_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RESET;
            char_count_reg <= CHAR_COUNT_RESET;
        end
        else
        begin
            start_char_reg <= start_char_next;
            char_count_reg <= char_count_next;
        end
    end

    // Front end: character assembly, index counting and the window test.
    ucwe_front #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .start_char (start_char_reg),
        .char_count (char_count_reg),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    // Jobs wait here so that a stalled receiver does not stop the input at once.
    ucwe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Back end: one result per cycle into the output register while the receiver takes them.
    ucwe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

@@ test/utf8_char_window_extract_tb.sv @@
// Self-checking testbench for the UTF-8 character window extractor.
`default_nettype none

module utf8_char_window_extract_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ucwe_pkg::*;

    // Index counter width of the instance; the index saturates at its top value.
    localparam int INDEX_BITS = 16;
    localparam int unsigned INDEX_TOP = (1 << INDEX_BITS) - 1;
    // Cycles to let pass once nothing is expected: covers the path through the job
    // queue and the output register.
    localparam int SETTLE_CYCLES = 8;
    // Mismatch lines beyond this count are counted but not printed.
    localparam int PRINT_CAP = 200;
    // Bytes 0xF8..0xFF never start a valid character.
    localparam logic [7:0] BAD_LEAD_BASE = 8'hF8;

    // Traffic shapes used by the phases of the run.
    typedef enum int {
        PACE_STEADY,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    // Tracks the window registers and the character state of the block and
    // keeps the results that each accepted byte should produce, in order.
    class char_window_scoreboard;
        out_item_t   expected_q[$];
        logic [15:0] start_char;
        logic [15:0] char_count;
        logic [7:0]  char_bytes[4];
        logic [2:0]  fill;
        logic [2:0]  char_len;
        int unsigned char_idx;
        bit          well_formed;
        int          errors;

        function new();
            start_char  = START_CHAR_RESET;
            char_count  = CHAR_COUNT_RESET;
            fill        = '0;
            char_len    = '0;
            char_idx    = 0;
            well_formed = 1'b1;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] data);
            if (index == CFG_START_CHAR)
            begin
                start_char = data;
            end
            else if (index == CFG_CHAR_COUNT)
            begin
                char_count = data;
            end
        endfunction

        // Character length announced by a lead byte; anything else counts as one byte.
        function logic [2:0] char_length_of(logic [7:0] b);
            casez (b)
                8'b0???????: return 3'd1;
                8'b110?????: return 3'd2;
                8'b1110????: return 3'd3;
                8'b11110???: return 3'd4;
                default:     return 3'd1;
            endcase
        endfunction

        function void push_result(logic [7:0] b, bit is_byte);
            out_item_t r;
            r.out_byte     = b;
            r.byte_present = is_byte;
            r.last         = !is_byte;
            r.char_total   = (char_idx > TOTAL_MAX) ? TOTAL_MAX : 16'(char_idx);
            r.well_formed  = well_formed;
            expected_q.push_back(r);
        endfunction

        function void note_request(in_item_t req);
            logic [7:0]  b;
            int unsigned pos;
            bit          in_window;
            int          i;
            b = req.data_byte;
            if (fill == 0)
            begin
                char_len = char_length_of(b);
            end
            else if ((b & CONT_MASK) != CONT_PAT)
            begin
                // A broken continuation byte still fills its slot in the character.
                well_formed = 1'b0;
            end
            char_bytes[fill[1:0]] = b;
            fill = fill + 3'd1;
            if (fill >= char_len)
            begin
                // The window test uses the index before the increment, with no wrap.
                pos = char_idx;
                in_window = (pos >= start_char) && ((pos - start_char) < char_count);
                if (char_idx < INDEX_TOP)
                begin
                    char_idx++;
                end
                if (in_window)
                begin
                    for (i = 0; i < fill && i < 4; i++)
                    begin
                        push_result(char_bytes[i], 1'b1);
                    end
                end
                fill = '0;
            end
            if (req.end_of_string)
            begin
                // A character cut off by the end mark is dropped and spoils the flag.
                if (fill != 0)
                begin
                    well_formed = 1'b0;
                end
                push_result(8'h00, 1'b0);
                fill        = '0;
                char_len    = '0;
                char_idx    = 0;
                well_formed = 1'b1;
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
            begin
                $display("%0t: mismatch: %s", $realtime, msg);
            end
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result byte=%02h present=%0b last=%0b",
                                 got.out_byte, got.byte_present, got.last));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
                if (got.byte_present !== want.byte_present)
                    report($sformatf("byte_present %0b, want %0b",
                                     got.byte_present, want.byte_present));
                if (got.last !== want.last)
                    report($sformatf("last %0b, want %0b", got.last, want.last));
                if (got.char_total !== want.char_total)
                    report($sformatf("char_total %0d, want %0d",
                                     got.char_total, want.char_total));
                if (got.well_formed !== want.well_formed)
                    report($sformatf("well_formed %0b, want %0b",
                                     got.well_formed, want.well_formed));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    pace_t       pace;
    // Remaining cycles of a forced receiver hold-off; counted by the receiver process.
    int          hold_off;
    in_item_t    string_q[$];

    char_window_scoreboard sb = new();

    utf8_char_window_extract #(
        .INDEX_WIDTH(INDEX_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; far above the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("utf8_char_window_extract_tb: done, errors");
        $finish;
    end

    // All handshakes are observed in one process, so a register write, an
    // accepted byte and a returned result on the same edge are handled in a
    // fixed order. Every driver uses nonblocking assignments, so the values
    // read here are the ones present at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_request(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
        end
    end

    function int sender_idle_pct();
        case (pace)
            PACE_SENDER_IDLE: return 55;
            PACE_BOTH:        return 21;
            default:          return 0;
        endcase
    endfunction

    function int receiver_stall_pct();
        case (pace)
            PACE_RECEIVER_STALL: return 55;
            PACE_BOTH:           return 21;
            default:             return 0;
        endcase
    endfunction

    // The receiver decides out_ready anew every cycle. A forced hold-off keeps
    // it low for a long stretch so that the job queue fills and in_ready drops.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    // Offers one request and returns at the edge where it is accepted. Idle
    // cycles, when the pace asks for them, come before the request is raised,
    // so valid is never lowered and raised again in the same time step.
    task automatic send_req(in_item_t req);
        int pct;
        pct = sender_idle_pct();
        if ($urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic add_byte(logic [7:0] b, bit eos);
        in_item_t req;
        req.data_byte     = b;
        req.end_of_string = eos;
        string_q.push_back(req);
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < string_q.size(); i++)
            send_req(string_q[i]);
        string_q.delete();
    endtask

    // Stops sending, waits until every expected result has come back, then lets
    // the block settle so a register write can follow safely.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both window registers back to back; cfg_valid stays high between them.
    task automatic set_window(logic [15:0] first, logic [15:0] count);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START_CHAR;
        cfg_data  <= first;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_CHAR_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Picks a window, mostly small so that characters actually pass, now and
    // then at the register extremes.
    task automatic random_window();
        logic [15:0] first;
        logic [15:0] count;
        case ($urandom_range(0, 5))
            0:       first = 16'd0;
            1:       first = 16'hFFFF;
            default: first = 16'($urandom_range(0, 5));
        endcase
        case ($urandom_range(0, 5))
            0:       count = 16'd0;
            1:       count = 16'hFFFF;
            2:       count = 16'd1;
            default: count = 16'($urandom_range(1, 6));
        endcase
        set_window(first, count);
    endtask

    function logic [7:0] bad_lead_byte();
        if ($urandom_range(0, 1) == 0)
            return CONT_PAT | 8'($urandom_range(0, 63));
        return BAD_LEAD_BASE | 8'($urandom_range(0, 7));
    endfunction

    // Any byte whose top two bits are not 10.
    function logic [7:0] bad_cont_byte();
        logic [1:0] top;
        top = 2'($urandom_range(0, 2));
        if (top == 2'd2)
            top = 2'd3;
        return {top, 6'($urandom_range(0, 63))};
    endfunction

    // Appends one character of the given length. With spoil set, one of its
    // continuation bytes is broken; with cut set, it loses at least its last byte.
    task automatic add_char(int len, bit spoil, bit cut);
        logic [7:0] lead;
        int         k;
        int         bad_at;
        int         keep;
        case (len)
            1:       lead = 8'($urandom_range(0, 127));
            2:       lead = LEAD2_PAT | 8'($urandom_range(0, 31));
            3:       lead = LEAD3_PAT | 8'($urandom_range(0, 15));
            default: lead = LEAD4_PAT | 8'($urandom_range(0, 7));
        endcase
        add_byte(lead, 1'b0);
        bad_at = (spoil && len > 1) ? $urandom_range(1, len - 1) : 0;
        keep = cut ? $urandom_range(1, len - 1) : len;
        for (k = 1; k < keep; k++)
        begin
            if (k == bad_at)
                add_byte(bad_cont_byte(), 1'b0);
            else
                add_byte(CONT_PAT | 8'($urandom_range(0, 63)), 1'b0);
        end
    endtask

    // Builds one string. Most are sequences of proper characters with random
    // content and the odd fault; some are raw noise.
    task automatic make_string();
        int n;
        int c;
        int pick;
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(1, 6);
            for (c = 0; c < n; c++)
                add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (c = 0; c < n; c++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    add_byte(bad_lead_byte(), 1'b0);
                else
                    add_char($urandom_range(1, 4), pick < 16, 1'b0);
            end
            if ($urandom_range(0, 99) < 15)
                add_char($urandom_range(2, 4), 1'b0, 1'b1);
        end
        string_q[string_q.size() - 1].end_of_string = 1'b1;
    endtask

    // One random phase. A hold-off, if given, starts with the phase while the
    // sender keeps offering; with a pause set, the sender stops halfway until
    // every expected result has arrived.
    task automatic run_random(pace_t p, int n_items, int hold, bit pause_mid);
        int sent;
        bit paused;
        pace     = p;
        hold_off = hold;
        sent     = 0;
        paused   = 1'b0;
        while (sent < n_items)
        begin
            make_string();
            sent += string_q.size();
            send_string();
            if (pause_mid && !paused && sent >= n_items / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_START_CHAR;
        cfg_data  <= '0;
        pace      = PACE_STEADY;
        hold_off  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full window: every complete character passes.
        set_window(16'd0, 16'hFFFF);

        // Smallest and largest one-byte characters (zero is not a terminator),
        // proper two-, three- and four-byte characters, then a stray
        // continuation byte and 0xFF as leads, which count as one byte each.
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b1);
        // A broken continuation byte: the character keeps its length, the flag drops.
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hF8, 1'b1);
        // A three-byte character cut off by the end mark is dropped.
        add_byte(8'h61, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        send_string();
        drain();

        // Empty window, then a write while a string is open: the new window
        // applies from the next completed character on.
        set_window(16'd0, 16'd0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        send_string();
        drain();
        set_window(16'd2, 16'd1);
        add_byte(8'h43, 1'b0);
        add_byte(8'h44, 1'b1);
        send_string();
        drain();

        // The window end lies past 65535; it must not wrap around to zero.
        set_window(16'd1, 16'hFFFF);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h43, 1'b1);
        send_string();
        drain();

        // Random phases, each with its own window and traffic shape.
        random_window();
        run_random(PACE_STEADY, 44, 60, 1'b0);
        random_window();
        run_random(PACE_SENDER_IDLE, 44, 0, 1'b1);
        random_window();
        run_random(PACE_RECEIVER_STALL, 44, 0, 1'b0);
        random_window();
        run_random(PACE_BOTH, 44, 0, 1'b0);

        if (sb.errors == 0)
        begin
            $display("utf8_char_window_extract_tb: done, clean");
        end
        else
        begin
            $display("utf8_char_window_extract_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
